@@ hw/rtl/gtms_pkg.sv @@
// ----------------------------------------------------------------------------
// Greedy triple match selector package
// Shared types and constants for the selector and its candidate cells.
// ----------------------------------------------------------------------------
`default_nettype none

package gtms_pkg;

    localparam int unsigned MaxCandidates = 64;
    localparam int unsigned ClusterIdBits = 16;
    localparam int unsigned HitBits       = 12;
    localparam int unsigned HitSumBits    = 14;
    localparam int unsigned Chi2Bits      = 16;
    localparam logic [Chi2Bits-1:0] MaxChi2Reset = 16'd256;

    typedef struct packed {
        logic                  have;
        logic [HitSumBits-1:0] hits;
        logic [Chi2Bits-1:0]   chi2;
    } best_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/gtms_cell.sv @@
// ----------------------------------------------------------------------------
// Candidate cell
// Holds one candidate triple and passes the best record seen so far down the
// chain, one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gtms_cell #(
    parameter int unsigned CLUSTER_ID_BITS = gtms_pkg::ClusterIdBits
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             load_en,
    input  wire  [CLUSTER_ID_BITS-1:0]      load_u,
    input  wire  [CLUSTER_ID_BITS-1:0]      load_v,
    input  wire  [CLUSTER_ID_BITS-1:0]      load_w,
    input  wire  [gtms_pkg::HitSumBits-1:0] load_hits,
    input  wire  [gtms_pkg::Chi2Bits-1:0]   load_chi2,
    input  wire  [gtms_pkg::Chi2Bits-1:0]   max_chi2,
    input  wire                             clear,
    input  wire                             retire,
    input  wire  [CLUSTER_ID_BITS-1:0]      ret_u,
    input  wire  [CLUSTER_ID_BITS-1:0]      ret_v,
    input  wire  [CLUSTER_ID_BITS-1:0]      ret_w,
    input  gtms_pkg::best_t                 best_in,
    input  wire  [CLUSTER_ID_BITS-1:0]      best_u_in,
    input  wire  [CLUSTER_ID_BITS-1:0]      best_v_in,
    input  wire  [CLUSTER_ID_BITS-1:0]      best_w_in,
    output gtms_pkg::best_t                 best_out,
    output logic [CLUSTER_ID_BITS-1:0]      best_u_out,
    output logic [CLUSTER_ID_BITS-1:0]      best_v_out,
    output logic [CLUSTER_ID_BITS-1:0]      best_w_out
);
    import gtms_pkg::*;

    logic                       alive_reg;
    logic [CLUSTER_ID_BITS-1:0] u_reg;
    logic [CLUSTER_ID_BITS-1:0] v_reg;
    logic [CLUSTER_ID_BITS-1:0] w_reg;
    logic [HitSumBits-1:0]      hits_reg;
    logic [Chi2Bits-1:0]        chi2_reg;
    best_t                      best_reg;
    best_t                      best_next;
    logic [CLUSTER_ID_BITS-1:0] bu_reg;
    logic [CLUSTER_ID_BITS-1:0] bv_reg;
    logic [CLUSTER_ID_BITS-1:0] bw_reg;
    logic                       better;
    logic                       hit_match;

    assign hit_match = (u_reg == ret_u) || (v_reg == ret_v) || (w_reg == ret_w);

    // Only a strictly better candidate displaces an earlier one.
    assign better = alive_reg && (chi2_reg <= max_chi2) &&
                    (!best_in.have || (hits_reg > best_in.hits) ||
                     ((hits_reg == best_in.hits) && (chi2_reg < best_in.chi2)));

    always_comb
    begin
        if (better)
        begin
            best_next.have = 1'b1;
            best_next.hits = hits_reg;
            best_next.chi2 = chi2_reg;
        end
        else
        begin
            best_next = best_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= 1'b0;
            best_reg  <= '0;
        end
        else
        begin
            if (clear)
            begin
                alive_reg <= 1'b0;
            end
            else if (load_en)
            begin
                alive_reg <= 1'b1;
            end
            else if (retire && hit_match)
            begin
                alive_reg <= 1'b0;
            end
            best_reg <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            u_reg    <= load_u;
            v_reg    <= load_v;
            w_reg    <= load_w;
            hits_reg <= load_hits;
            chi2_reg <= load_chi2;
        end
        bu_reg <= better ? u_reg : best_u_in;
        bv_reg <= better ? v_reg : best_v_in;
        bw_reg <= better ? w_reg : best_w_in;
    end

    assign best_out   = best_reg;
    assign best_u_out = bu_reg;
    assign best_v_out = bv_reg;
    assign best_w_out = bw_reg;

endmodule

`default_nettype wire

@@ hw/rtl/greedy_triple_match_selector.sv @@
// ----------------------------------------------------------------------------
// Greedy triple match selector
// Loads candidate triples into a chain of cells and picks conflict-free
// triples greedily by hit sum, chi-square and load order.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Direction  Payload
//  request   start / busy          in         id_u..id_w, hits_u..w, fit_chi2,
//                                             final_item
//  result    done (one cycle)      out        found, pick_u..w, pick_hits,
//                                             run_end
//  config    max_chi2_we           in         max_chi2_wdata
//
//  A final request starts a run in which each round lasts while the best record
//  travels the full chain of cells; a run of R picks takes (R + 1) rounds.
//  Reset clears all cells and the load count; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_triple_match_selector #(
    parameter int unsigned MAX_CANDIDATES  = gtms_pkg::MaxCandidates,
    parameter int unsigned CLUSTER_ID_BITS = gtms_pkg::ClusterIdBits
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire  [CLUSTER_ID_BITS-1:0]    id_u,
    input  wire  [CLUSTER_ID_BITS-1:0]    id_v,
    input  wire  [CLUSTER_ID_BITS-1:0]    id_w,
    input  wire  [gtms_pkg::HitBits-1:0]  hits_u,
    input  wire  [gtms_pkg::HitBits-1:0]  hits_v,
    input  wire  [gtms_pkg::HitBits-1:0]  hits_w,
    input  wire  [gtms_pkg::Chi2Bits-1:0] fit_chi2,
    input  wire                           final_item,
    input  wire                           max_chi2_we,
    input  wire  [gtms_pkg::Chi2Bits-1:0] max_chi2_wdata,
    output logic                          done,
    output logic                          found,
    output logic [CLUSTER_ID_BITS-1:0]    pick_u,
    output logic [CLUSTER_ID_BITS-1:0]    pick_v,
    output logic [CLUSTER_ID_BITS-1:0]    pick_w,
    output logic [gtms_pkg::HitSumBits-1:0] pick_hits,
    output logic                          run_end
);
    import gtms_pkg::*;

    localparam int unsigned CntBits = $clog2(MAX_CANDIDATES + 1);

    state_t                     state_reg;
    logic [CntBits-1:0]         count_reg;
    logic [CntBits-1:0]         scan_reg;
    logic [Chi2Bits-1:0]        max_chi2_reg;
    logic                       pend_reg;
    logic [CLUSTER_ID_BITS-1:0] pend_u_reg;
    logic [CLUSTER_ID_BITS-1:0] pend_v_reg;
    logic [CLUSTER_ID_BITS-1:0] pend_w_reg;
    logic [HitSumBits-1:0]      pend_hits_reg;
    logic                       done_reg;
    logic                       found_reg;
    logic [CLUSTER_ID_BITS-1:0] pu_reg;
    logic [CLUSTER_ID_BITS-1:0] pv_reg;
    logic [CLUSTER_ID_BITS-1:0] pw_reg;
    logic [HitSumBits-1:0]      ph_reg;
    logic                       end_reg;

    logic                       accept;
    logic                       store_en;
    logic                       scan_end;
    logic                       retire;
    logic                       clear;
    logic [HitSumBits-1:0]      load_hits;

    best_t                      chain   [MAX_CANDIDATES+1];
    logic [CLUSTER_ID_BITS-1:0] chain_u [MAX_CANDIDATES+1];
    logic [CLUSTER_ID_BITS-1:0] chain_v [MAX_CANDIDATES+1];
    logic [CLUSTER_ID_BITS-1:0] chain_w [MAX_CANDIDATES+1];

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign store_en  = accept && (count_reg < CntBits'(MAX_CANDIDATES));
    assign scan_end  = (state_reg == ST_SCAN) && (scan_reg == CntBits'(MAX_CANDIDATES));
    assign retire    = scan_end && chain[MAX_CANDIDATES].have;
    assign clear     = scan_end && !chain[MAX_CANDIDATES].have;
    assign load_hits = HitSumBits'(hits_u) + HitSumBits'(hits_v) + HitSumBits'(hits_w);

    assign chain[0].have = 1'b0;
    assign chain[0].hits = '0;
    assign chain[0].chi2 = '0;
    assign chain_u[0]    = '0;
    assign chain_v[0]    = '0;
    assign chain_w[0]    = '0;

    for (genvar i = 0; i < MAX_CANDIDATES; i++)
    begin : g_cell
        gtms_cell #(
            .CLUSTER_ID_BITS(CLUSTER_ID_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load_en    (store_en && (count_reg == CntBits'(i))),
            .load_u     (id_u),
            .load_v     (id_v),
            .load_w     (id_w),
            .load_hits  (load_hits),
            .load_chi2  (fit_chi2),
            .max_chi2   (max_chi2_reg),
            .clear      (clear),
            .retire     (retire),
            .ret_u      (chain_u[MAX_CANDIDATES]),
            .ret_v      (chain_v[MAX_CANDIDATES]),
            .ret_w      (chain_w[MAX_CANDIDATES]),
            .best_in    (chain[i]),
            .best_u_in  (chain_u[i]),
            .best_v_in  (chain_v[i]),
            .best_w_in  (chain_w[i]),
            .best_out   (chain[i+1]),
            .best_u_out (chain_u[i+1]),
            .best_v_out (chain_v[i+1]),
            .best_w_out (chain_w[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_reg     <= '0;
            max_chi2_reg <= MaxChi2Reset;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (max_chi2_we)
            begin
                max_chi2_reg <= max_chi2_wdata;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (store_en)
                    begin
                        count_reg <= count_reg + CntBits'(1);
                    end
                    if (accept && final_item)
                    begin
                        scan_reg  <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_end)
                    begin
                        scan_reg <= '0;
                        done_reg <= pend_reg || clear;
                        pend_reg <= retire;
                        if (clear)
                        begin
                            count_reg <= '0;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        scan_reg <= scan_reg + CntBits'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_end)
        begin
            found_reg <= pend_reg;
            pu_reg    <= pend_reg ? pend_u_reg : '0;
            pv_reg    <= pend_reg ? pend_v_reg : '0;
            pw_reg    <= pend_reg ? pend_w_reg : '0;
            ph_reg    <= pend_reg ? pend_hits_reg : '0;
            end_reg   <= clear;
        end
        if (retire)
        begin
            pend_u_reg    <= chain_u[MAX_CANDIDATES];
            pend_v_reg    <= chain_v[MAX_CANDIDATES];
            pend_w_reg    <= chain_w[MAX_CANDIDATES];
            pend_hits_reg <= chain[MAX_CANDIDATES].hits;
        end
    end

    assign done      = done_reg;
    assign found     = found_reg;
    assign pick_u    = pu_reg;
    assign pick_v    = pv_reg;
    assign pick_w    = pw_reg;
    assign pick_hits = ph_reg;
    assign run_end   = end_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Greedy triple match selector testbench
// Loads candidate lists, lets the selector run and checks every pick against
// a behavioural selector kept in the bench. Directed lists come first, then an
// overfull load, then random lists with shared cluster identifiers.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int NCAND = gtms_pkg::MaxCandidates;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        logic        found;
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] w;
        logic [13:0] hits;
        logic        last;
    } pick_t;

    typedef struct {
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] w;
        logic [11:0] hu;
        logic [11:0] hv;
        logic [11:0] hw;
        logic [15:0] chi2;
        logic        fin;
    } cand_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [15:0] id_u = '0, id_v = '0, id_w = '0;
    logic [11:0] hits_u = '0, hits_v = '0, hits_w = '0;
    logic [15:0] fit_chi2 = '0;
    logic final_item = 1'b0;
    logic max_chi2_we = 1'b0;
    logic [15:0] max_chi2_wdata = '0;
    logic done, found, run_end;
    logic [15:0] pick_u, pick_v, pick_w;
    logic [13:0] pick_hits;

    logic [15:0] sel_u[NCAND], sel_v[NCAND], sel_w[NCAND], sel_chi2[NCAND];
    logic [13:0] sel_hits[NCAND];
    logic        sel_alive[NCAND];
    int          sel_count = 0;
    logic [15:0] chi2_limit = gtms_pkg::MaxChi2Reset;

    pick_t expected_picks[$];
    int    mismatch_count = 0;
    int    idle_cycles = 0;
    cand_t directed_list[$];

    always #6 clk = ~clk;

    greedy_triple_match_selector dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .id_u(id_u), .id_v(id_v), .id_w(id_w),
        .hits_u(hits_u), .hits_v(hits_v), .hits_w(hits_w),
        .fit_chi2(fit_chi2), .final_item(final_item),
        .max_chi2_we(max_chi2_we), .max_chi2_wdata(max_chi2_wdata),
        .done(done), .found(found), .pick_u(pick_u), .pick_v(pick_v),
        .pick_w(pick_w), .pick_hits(pick_hits), .run_end(run_end)
    );

    function automatic void add_pick(pick_t p);
        expected_picks.insert(expected_picks.size(), p);
    endfunction

    function automatic void add_row(cand_t c);
        directed_list.insert(directed_list.size(), c);
    endfunction

    function automatic void predict_request(cand_t c);
        int best;
        pick_t p;
        int first;
        if (sel_count < NCAND) begin
            sel_u[sel_count] = c.u;
            sel_v[sel_count] = c.v;
            sel_w[sel_count] = c.w;
            sel_hits[sel_count] = 14'(c.hu) + 14'(c.hv) + 14'(c.hw);
            sel_chi2[sel_count] = c.chi2;
            sel_alive[sel_count] = 1'b1;
            sel_count++;
        end
        if (!c.fin)
            return;
        first = expected_picks.size();
        forever begin
            best = -1;
            for (int i = 0; i < sel_count; i++) begin
                if (!sel_alive[i] || sel_chi2[i] > chi2_limit)
                    continue;
                if (best < 0 || sel_hits[i] > sel_hits[best] ||
                    (sel_hits[i] == sel_hits[best] && sel_chi2[i] < sel_chi2[best]))
                    best = i;
            end
            if (best < 0)
                break;
            p = '{1'b1, sel_u[best], sel_v[best], sel_w[best], sel_hits[best], 1'b0};
            add_pick(p);
            for (int i = 0; i < sel_count; i++)
                if (sel_u[i] == p.u || sel_v[i] == p.v || sel_w[i] == p.w)
                    sel_alive[i] = 1'b0;
        end
        if (expected_picks.size() == first)
            add_pick('{1'b0, 16'd0, 16'd0, 16'd0, 14'd0, 1'b1});
        else
            expected_picks[expected_picks.size() - 1].last = 1'b1;
        for (int i = 0; i < NCAND; i++)
            sel_alive[i] = 1'b0;
        sel_count = 0;
    endfunction

    always @(posedge clk) begin
        if (rst_n && done) begin
            pick_t e;
            if (expected_picks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: found=%0d u=%h v=%h w=%h hits=%0d end=%0d",
                             found, pick_u, pick_v, pick_w, pick_hits, run_end);
            end else begin
                e = expected_picks.pop_front();
                if (found !== e.found || pick_u !== e.u || pick_v !== e.v ||
                    pick_w !== e.w || pick_hits !== e.hits || run_end !== e.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %0d %h %h %h %0d %0d, got %0d %h %h %h %0d %0d",
                                 e.found, e.u, e.v, e.w, e.hits, e.last,
                                 found, pick_u, pick_v, pick_w, pick_hits, run_end);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic random_gap();
        int n;
        if ($urandom_range(0, 3) == 0)
            return;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        repeat (n) @(negedge clk);
    endtask

    // A request is held until it is accepted at a rising edge with busy low.
    task automatic send_request(cand_t c);
        @(negedge clk);
        start <= 1'b1;
        id_u <= c.u; id_v <= c.v; id_w <= c.w;
        hits_u <= c.hu; hits_v <= c.hv; hits_w <= c.hw;
        fit_chi2 <= c.chi2; final_item <= c.fin;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        predict_request(c);
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic drain_and_write(logic [15:0] value);
        while (expected_picks.size() != 0)
            @(negedge clk);
        repeat (2 * NCAND + 8) @(negedge clk);
        max_chi2_we <= 1'b1;
        max_chi2_wdata <= value;
        @(negedge clk);
        max_chi2_we <= 1'b0;
        chi2_limit = value;
    endtask

    function automatic cand_t random_cand(int id_span, bit fin);
        cand_t c;
        c.u = (id_span == 0) ? 16'($urandom) : 16'($urandom_range(0, id_span));
        c.v = (id_span == 0) ? 16'($urandom) : 16'($urandom_range(0, id_span));
        c.w = (id_span == 0) ? 16'($urandom) : 16'($urandom_range(0, id_span));
        c.hu = ($urandom_range(0, 7) == 0) ? 12'hFFF : 12'($urandom_range(0, 40));
        c.hv = ($urandom_range(0, 7) == 0) ? 12'hFFF : 12'($urandom_range(0, 40));
        c.hw = ($urandom_range(0, 7) == 0) ? 12'hFFF : 12'($urandom_range(0, 40));
        case ($urandom_range(0, 3))
            0: c.chi2 = 16'($urandom);
            1: c.chi2 = chi2_limit;
            default: c.chi2 = 16'($urandom_range(0, 400));
        endcase
        c.fin = fin;
        return c;
    endfunction

    initial begin
        int len;
        int sent;
        logic [15:0] limits[4];
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes, a tie on hit sum broken by chi-square, a tie broken by load
        // order, duplicates, a list that qualifies nothing and an over-limit pick.
        add_row('{16'h0000, 16'h0000, 16'h0000, 12'h000, 12'h000, 12'h000,
                  16'h0000, 1'b1});
        add_row('{16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                  16'h0100, 1'b1});
        add_row('{16'h0001, 16'h0002, 16'h0003, 12'd5, 12'd5, 12'd5,
                  16'h0101, 1'b1});
        add_row('{16'h0010, 16'h0020, 16'h0030, 12'd10, 12'd0, 12'd0,
                  16'h0080, 1'b0});
        add_row('{16'h0011, 16'h0020, 16'h0031, 12'd4, 12'd6, 12'd0,
                  16'h0040, 1'b0});
        add_row('{16'h0012, 16'h0022, 16'h0032, 12'd9, 12'd0, 12'd0,
                  16'h0040, 1'b0});
        add_row('{16'h0013, 16'h0023, 16'h0033, 12'd9, 12'd0, 12'd0,
                  16'h0040, 1'b0});
        add_row('{16'h0010, 16'h0020, 16'h0030, 12'd10, 12'd0, 12'd0,
                  16'h0080, 1'b0});
        add_row('{16'hAAAA, 16'h5555, 16'hAAAA, 12'hAAA, 12'h555, 12'hAAA,
                  16'hFFFF, 1'b1});
        foreach (directed_list[k]) begin
            send_request(directed_list[k]);
            random_gap();
        end
        drain_and_write(16'hFFFF);
        directed_list[8].fin = 1'b1;
        send_request(directed_list[8]);
        drain_and_write(16'h0000);
        send_request(directed_list[0]);
        send_request(directed_list[2]);

        // Overfull store: the surplus requests are dropped, the final one still runs.
        drain_and_write(16'hFFFF);
        for (int i = 0; i < NCAND + 3; i++)
            send_request(random_cand(12, i == NCAND + 2));

        limits = '{16'd256, 16'd0, 16'd300, 16'hFFFF};
        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            drain_and_write(limits[phase]);
            while (sent < 12 * (phase + 1)) begin
                len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 8);
                for (int i = 0; i < len; i++) begin
                    send_request(random_cand(($urandom_range(0, 5) == 0) ? 0 : 6,
                                             i == len - 1));
                    sent++;
                    random_gap();
                end
            end
        end

        while (expected_picks.size() != 0)
            @(negedge clk);
        repeat (2 * NCAND + 8) @(negedge clk);
        if (mismatch_count == 0 && expected_picks.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/gtms_pkg.sv
hw/rtl/gtms_cell.sv
hw/rtl/greedy_triple_match_selector.sv
tb/sv/tb.sv
